### rtl/dcp_pkg.sv
package dcp_pkg;

  // Default number of decoded requests held between the front and back parts.
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  // Command letters (ASCII).
  localparam logic [7:0] LETTER_REG_READ   = 8'h72; // 'r'
  localparam logic [7:0] LETTER_REG_WRITE  = 8'h52; // 'R'
  localparam logic [7:0] LETTER_MEM_READ   = 8'h6D; // 'm'
  localparam logic [7:0] LETTER_MEM_WRITE  = 8'h4D; // 'M'
  localparam logic [7:0] LETTER_BP_SET     = 8'h62; // 'b'
  localparam logic [7:0] LETTER_BP_CLEAR   = 8'h42; // 'B'
  localparam logic [7:0] LETTER_WP_SET     = 8'h77; // 'w'
  localparam logic [7:0] LETTER_WP_CLEAR   = 8'h57; // 'W'
  localparam logic [7:0] LETTER_CONTINUE   = 8'h63; // 'c'
  localparam logic [7:0] LETTER_CPU_CTRL   = 8'h43; // 'C'
  localparam logic [7:0] LETTER_DETACH     = 8'h44; // 'D'
  localparam logic [7:0] LETTER_STEP       = 8'h73; // 's'
  localparam logic [7:0] LETTER_LOAD       = 8'h4C; // 'L'

  // Opcodes placed in bits 23..16 of the header.
  localparam logic [7:0] OP_NONE          = 8'd0;
  localparam logic [7:0] OP_IU_READ       = 8'd1;
  localparam logic [7:0] OP_IU_WRITE      = 8'd2;
  localparam logic [7:0] OP_FP_READ       = 8'd3;
  localparam logic [7:0] OP_FP_WRITE      = 8'd4;
  localparam logic [7:0] OP_MEM_READ      = 8'd6;
  localparam logic [7:0] OP_MEM_WRITE     = 8'd7;
  localparam logic [7:0] OP_BP_SET        = 8'd8;
  localparam logic [7:0] OP_BP_CLEAR      = 8'd9;
  localparam logic [7:0] OP_WP_SET        = 8'd10;
  localparam logic [7:0] OP_WP_CLEAR      = 8'd11;
  localparam logic [7:0] OP_PC_READ       = 8'd13;
  localparam logic [7:0] OP_PC_WRITE      = 8'd14;
  localparam logic [7:0] OP_DETACH        = 8'd15;
  localparam logic [7:0] OP_CONTINUE      = 8'd16;
  localparam logic [7:0] OP_CPSR_READ     = 8'd17;
  localparam logic [7:0] OP_CPSR_WRITE    = 8'd18;

  // Register ids with a fixed meaning.
  localparam logic [7:0] REG_FP_FIRST  = 8'd32;
  localparam logic [7:0] REG_Y         = 8'd64;
  localparam logic [7:0] REG_PSR       = 8'd65;
  localparam logic [7:0] REG_WIM       = 8'd66;
  localparam logic [7:0] REG_TBR       = 8'd67;
  localparam logic [7:0] REG_PC        = 8'd68;
  localparam logic [7:0] REG_NPC       = 8'd69;
  localparam logic [7:0] REG_FSR       = 8'd70;
  localparam logic [7:0] REG_CPSR      = 8'd71;
  localparam logic [7:0] REG_ANC_FIRST = 8'd77;
  localparam logic [7:0] REG_ANC_LAST  = 8'd108;

  // Command field codes.
  localparam logic [15:0] FIELD_IU_BASE  = 16'h0400;
  localparam logic [15:0] FIELD_Y        = 16'h0040;
  localparam logic [15:0] FIELD_PSR      = 16'h0200;
  localparam logic [15:0] FIELD_WIM      = 16'h0100;
  localparam logic [15:0] FIELD_TBR      = 16'h0080;
  localparam logic [15:0] FIELD_ANC_BASE = 16'h0020;
  localparam logic [15:0] FIELD_FSR      = 16'h0020;
  localparam logic [15:0] FIELD_PC       = 16'h0001;
  localparam logic [15:0] FIELD_NPC      = 16'h0002;

  // One classified request as it waits for the back part.
  typedef struct packed {
    logic [31:0] header;
    logic [31:0] address;
    logic [31:0] data;
    logic        send_address;
    logic        send_data;
  } dcp_entry_t;

  // Status of the request queue.
  typedef struct packed {
    logic full;
    logic empty;
  } dcp_queue_status_t;

endpackage

### rtl/dcp_front.sv
module dcp_front (
  input  logic [7:0]         req_type,
  input  logic [7:0]         reg_id,
  input  logic [31:0]        write_data,
  input  logic [31:0]        target_address,
  output dcp_pkg::dcp_entry_t entry
);

  // Opcode and command field for register reads and writes.
  function automatic logic [23:0] reg_header(input logic is_write, input logic [7:0] rid);
    logic [7:0]  op;
    logic [15:0] field;
    op    = dcp_pkg::OP_NONE;
    field = 16'h0000;
    if (rid < dcp_pkg::REG_FP_FIRST || (rid >= dcp_pkg::REG_Y && rid <= dcp_pkg::REG_TBR) ||
        (rid >= dcp_pkg::REG_ANC_FIRST && rid <= dcp_pkg::REG_ANC_LAST)) begin
      op = is_write ? dcp_pkg::OP_IU_WRITE : dcp_pkg::OP_IU_READ;
      if (rid < dcp_pkg::REG_FP_FIRST) field = dcp_pkg::FIELD_IU_BASE + {8'd0, rid};
      else if (rid == dcp_pkg::REG_Y) field = dcp_pkg::FIELD_Y;
      else if (rid == dcp_pkg::REG_PSR) field = dcp_pkg::FIELD_PSR;
      else if (rid == dcp_pkg::REG_WIM) field = dcp_pkg::FIELD_WIM;
      else if (rid == dcp_pkg::REG_TBR) field = dcp_pkg::FIELD_TBR;
      else field = dcp_pkg::FIELD_ANC_BASE + {8'd0, rid - dcp_pkg::REG_ANC_FIRST};
    end else if ((rid >= dcp_pkg::REG_FP_FIRST && rid < dcp_pkg::REG_Y) ||
                 rid == dcp_pkg::REG_FSR) begin
      op = is_write ? dcp_pkg::OP_FP_WRITE : dcp_pkg::OP_FP_READ;
      field = (rid == dcp_pkg::REG_FSR) ? dcp_pkg::FIELD_FSR
                                        : {8'd0, rid - dcp_pkg::REG_FP_FIRST};
    end else if (rid == dcp_pkg::REG_PC || rid == dcp_pkg::REG_NPC) begin
      op = is_write ? dcp_pkg::OP_PC_WRITE : dcp_pkg::OP_PC_READ;
      field = (rid == dcp_pkg::REG_PC) ? dcp_pkg::FIELD_PC : dcp_pkg::FIELD_NPC;
    end else if (rid == dcp_pkg::REG_CPSR) begin
      op = is_write ? dcp_pkg::OP_CPSR_WRITE : dcp_pkg::OP_CPSR_READ;
    end
    return {op, field};
  endfunction

  logic [7:0]  length;
  logic [23:0] body;
  logic [15:0] slot_field;
  logic        send_address;
  logic        send_data;

  // Breakpoint and watchpoint slot: group from the data word, then the id.
  assign slot_field = {12'd0, write_data[1:0], 2'b00} + {8'd0, reg_id};

  always_comb begin
    case (req_type)
      dcp_pkg::LETTER_REG_READ, dcp_pkg::LETTER_CPU_CTRL, dcp_pkg::LETTER_CONTINUE,
      dcp_pkg::LETTER_DETACH, dcp_pkg::LETTER_STEP, dcp_pkg::LETTER_LOAD: length = 8'd1;
      dcp_pkg::LETTER_MEM_READ, dcp_pkg::LETTER_BP_SET, dcp_pkg::LETTER_BP_CLEAR,
      dcp_pkg::LETTER_WP_SET, dcp_pkg::LETTER_WP_CLEAR, dcp_pkg::LETTER_REG_WRITE: length = 8'd2;
      dcp_pkg::LETTER_MEM_WRITE: length = 8'd3;
      default: length = 8'd0;
    endcase
  end

  always_comb begin
    send_address = 1'b0;
    send_data    = 1'b0;
    case (req_type)
      dcp_pkg::LETTER_REG_READ: begin
        body = reg_header(1'b0, reg_id);
      end
      dcp_pkg::LETTER_REG_WRITE: begin
        body = reg_header(1'b1, reg_id);
        send_data = 1'b1;
      end
      dcp_pkg::LETTER_MEM_READ: begin
        body = {dcp_pkg::OP_MEM_READ, 8'd0, reg_id};
        send_address = 1'b1;
      end
      dcp_pkg::LETTER_MEM_WRITE: begin
        body = {dcp_pkg::OP_MEM_WRITE, 8'd0, reg_id};
        send_address = 1'b1;
        send_data    = 1'b1;
      end
      dcp_pkg::LETTER_BP_SET: begin
        body = {dcp_pkg::OP_BP_SET, slot_field};
        send_address = 1'b1;
      end
      dcp_pkg::LETTER_BP_CLEAR: begin
        body = {dcp_pkg::OP_BP_CLEAR, slot_field};
        send_address = 1'b1;
      end
      dcp_pkg::LETTER_WP_SET: begin
        body = {dcp_pkg::OP_WP_SET, slot_field};
        send_address = 1'b1;
      end
      dcp_pkg::LETTER_WP_CLEAR: begin
        body = {dcp_pkg::OP_WP_CLEAR, slot_field};
        send_address = 1'b1;
      end
      dcp_pkg::LETTER_CONTINUE: body = {dcp_pkg::OP_CONTINUE, 16'h0000};
      dcp_pkg::LETTER_CPU_CTRL: body = {dcp_pkg::OP_PC_WRITE, 16'h0000};
      dcp_pkg::LETTER_DETACH:   body = {dcp_pkg::OP_DETACH, 16'h0000};
      default: body = 24'd0;
    endcase
  end

  assign entry.header       = {length, body};
  assign entry.address      = target_address;
  assign entry.data         = write_data;
  assign entry.send_address = send_address;
  assign entry.send_data    = send_data;

endmodule

### rtl/dcp_queue.sv
module dcp_queue #(
  parameter int DEPTH = dcp_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  dcp_pkg::dcp_entry_t        push_entry,
  input  logic                       pop,
  output dcp_pkg::dcp_entry_t        head,
  output dcp_pkg::dcp_queue_status_t status
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  dcp_pkg::dcp_entry_t slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] ptr);
    return (ptr == PW'(DEPTH - 1)) ? '0 : ptr + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= bump(wr_ptr);
      if (pop) rd_ptr <= bump(rd_ptr);
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  assign head         = slots[rd_ptr];
  assign status.full  = (count == CW'(DEPTH));
  assign status.empty = (count == '0);

endmodule

### rtl/dcp_back.sv
module dcp_back (
  input  logic                clk,
  input  logic                rst,
  input  dcp_pkg::dcp_entry_t head,
  input  logic                head_valid,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [31:0]         packet_word,
  output logic                last_word
);

  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_ADDRESS = 3'b010,
    PH_DATA    = 3'b100
  } phase_t;

  phase_t      phase;
  phase_t      phase_next;
  logic        load;
  logic [31:0] word;
  logic        last;

  assign load = head_valid && (!out_valid || !out_stall);

  always_comb begin
    case (phase)
      PH_HEADER: begin
        word       = head.header;
        last       = !head.send_address && !head.send_data;
        phase_next = head.send_address ? PH_ADDRESS : PH_DATA;
      end
      PH_ADDRESS: begin
        word       = head.address;
        last       = !head.send_data;
        phase_next = PH_DATA;
      end
      PH_DATA: begin
        word       = head.data;
        last       = 1'b1;
        phase_next = PH_HEADER;
      end
      default: begin
        word       = head.header;
        last       = 1'b1;
        phase_next = PH_HEADER;
      end
    endcase
    if (last) phase_next = PH_HEADER;
  end

  assign pop = load && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HEADER;
      out_valid <= 1'b0;
    end else if (load) begin
      phase     <= phase_next;
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      packet_word <= word;
      last_word   <= last;
    end
  end

endmodule

### rtl/debug_command_packetizer_unit.sv
// Debug command packetizer.
//
// The input channel takes one debugger request per beat: command letter,
// register id, data word and address. The output channel gives one 32-bit
// word per beat: first the header (length, opcode, command field), then the
// address for memory, breakpoint and watchpoint commands, then the data word
// for register and memory writes. last_word is high on the final beat of a
// request.
//
// Both channels use valid and stall. An accepted request is classified at
// once and written into a small queue; the first word of a request that finds
// the queue empty passes from its queue slot into the output register.
// The output register sends one word per cycle while out_stall is low, so
// a request occupies the output for one beat per word, one to three words;
// that single word-wide output register is what sets the sustained rate.
// The input stalls only while the queue is full. A stall on the output holds
// the word on display and the queue fills behind it.
// Reset empties the queue, returns the word sequencer to the header and
// drops output valid; no item survives it.
module debug_command_packetizer_unit #(
  parameter int QUEUE_DEPTH = dcp_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  req_type,
  input  logic [7:0]  reg_id,
  input  logic [31:0] write_data,
  input  logic [31:0] target_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] packet_word,
  output logic        last_word
);

  dcp_pkg::dcp_entry_t        decoded;
  dcp_pkg::dcp_entry_t        head;
  dcp_pkg::dcp_queue_status_t q_status;
  logic                       push;
  logic                       pop;

  // Front part: classify the request into its header and word plan.
  dcp_front u_front (
    .req_type       (req_type),
    .reg_id         (reg_id),
    .write_data     (write_data),
    .target_address (target_address),
    .entry          (decoded)
  );

  assign in_stall = q_status.full;
  assign push     = in_valid && !q_status.full;

  // Queue between the two parts, so each side stalls on its own.
  dcp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (decoded),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  // Back part: walk the words of the head request into the output register.
  dcp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .head_valid  (!q_status.empty),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .packet_word (packet_word),
    .last_word   (last_word)
  );

  // A request is only retired from the queue when one is waiting there.
  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_status.empty)
    else $error("request retired from an empty queue");

  // The queue can never be full and empty at once.
  a_status_consistent: assert property (@(posedge clk) disable iff (rst)
    !(q_status.full && q_status.empty))
    else $error("queue reports full and empty together");

  // Reset leaves no beat on the output and no request in the queue.
  a_reset_clears: assert property (@(posedge clk)
    rst |=> (!out_valid && q_status.empty))
    else $error("state survived reset");

  // A word shown while stalled is the one shown in the next cycle.
  a_stall_holds_word: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(packet_word) && $stable(last_word)))
    else $error("stalled output word changed");

endmodule
